### rtl/gfgr_pkg.sv
// gfgr_pkg: constants, state type and color blend helpers for the glyph row renderer
// no dependencies
package gfgr_pkg;

    localparam int MAX_CHARS       = 256;
    localparam int MAX_GLYPH_WIDTH = 32;
    localparam int MAX_HEIGHT      = 32;
    localparam int STRIP_BYTES     = 16384;

    localparam int CODE_W  = $clog2(MAX_CHARS);
    localparam int STRIP_W = $clog2(STRIP_BYTES);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);

    localparam logic [1:0] OP_LOAD_WIDTH = 2'd0;
    localparam logic [1:0] OP_LOAD_STRIP = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;
    localparam logic [1:0] OP_NONE       = 2'd3;

    localparam logic [1:0] REG_TEXT_COLOR  = 2'd0;
    localparam logic [1:0] REG_BACK_COLOR  = 2'd1;
    localparam logic [1:0] REG_FONT_HEIGHT = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WLOAD  = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_PIX_RD = 6'b001000,
        ST_PIX_LD = 6'b010000,
        ST_RES    = 6'b100000
    } state_t;

    // floor(v / 3) for v below 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [20:0] prod;
        prod = 21'(v) * 21'd683;
        return prod[18:11];
    endfunction

    // level 1 when two_thirds is 0, level 2 when 1; each term rounded to nearest
    function automatic logic [23:0] blend(input logic two_thirds, input logic [23:0] fg,
                                          input logic [23:0] bg);
        logic [23:0] res;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  ta;
        logic [7:0]  tb;
        res = '0;
        for (int c = 0; c < 3; c++) begin
            a = fg[c*8 +: 8];
            b = bg[c*8 +: 8];
            if (two_thirds) begin
                ta = div3({1'b0, a, 1'b1});
                tb = div3(10'(b) + 10'd1);
            end
            else begin
                ta = div3(10'(a) + 10'd1);
                tb = div3({1'b0, b, 1'b1});
            end
            res[c*8 +: 8] = ta + tb;
        end
        return res;
    endfunction

endpackage

### rtl/gray_font_glyph_row_renderer_unit.sv
// gray_font_glyph_row_renderer_unit: renders one row of a 2-bit grayscale glyph to rgb pixels
// depends on gfgr_pkg
//
// input items on s_axis: op in s_tuser; op 0 loads a width entry, op 1 a strip byte,
// op 2 draws a glyph row. a strip load is written as it is accepted; a width load
// is a read-modify-write through ST_WLOAD. a draw first sweeps the width table memory
// from code 0 up to the drawn code, one entry per cycle, to form the start column.
// then each pixel is a strip memory read, then a load of the output register, which
// waits while the receiver stalls. bad code or row gives a single status item;
// a zero-width glyph gives a single empty item.
// results leave on m_axis through one output register; a stalled receiver holds it
// and the block waits. only one input item is in work at a time.
// configuration writes (text color, back color, font height) are taken any cycle.
// reset clears the width table valid bits, total width and control state; the strip
// memory is undefined until written.
module gray_font_glyph_row_renderer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code, address, data, row, x, y, zero pad
    input  logic [71:0] s_tdata,
    // op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_x, pixel_y, pixel_color, glyph_width
    output logic [55:0] m_tdata,
    // pixel_valid, status
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import gfgr_pkg::*;

    logic [15:0] in_code;
    logic [13:0] in_addr;
    logic [7:0]  in_data;
    logic [7:0]  in_row;
    logic [11:0] in_x;
    logic [11:0] in_y;

    assign in_code = s_tdata[15:0];
    assign in_addr = s_tdata[29:16];
    assign in_data = s_tdata[37:30];
    assign in_row  = s_tdata[45:38];
    assign in_x    = s_tdata[57:46];
    assign in_y    = s_tdata[69:58];

    state_t state_reg, state_next;

    logic [23:0] text_reg;
    logic [23:0] back_reg;
    logic [5:0]  height_reg;
    logic [13:0] total_reg;

    logic [5:0]  wmem [MAX_CHARS];
    logic        wvalid_reg [MAX_CHARS];
    logic [5:0]  wrd_q;
    logic        wrd_valid_q;
    logic        wrd_en;
    logic [CODE_W-1:0] wrd_addr;

    logic [7:0]  smem [STRIP_BYTES];
    logic [7:0]  srd_q;
    logic        srd_en;
    logic [STRIP_W-1:0] srd_addr;

    logic [CODE_W-1:0] code_reg;
    logic [5:0]  wload_reg;
    logic [11:0] x_reg;
    logic [12:0] py_reg;
    logic        bad_reg;
    logic [CODE_W-1:0] cnt_reg;
    logic [12:0] start_reg;
    logic [5:0]  w_reg;
    logic [5:0]  i_reg;
    logic [17:0] base_reg;
    logic [1:0]  sel_reg;

    logic        out_valid_reg;
    logic [12:0] out_px_reg;
    logic [12:0] out_py_reg;
    logic [23:0] out_color_reg;
    logic [5:0]  out_gw_reg;
    logic        out_pv_reg;
    logic        out_status_reg;
    logic        out_last_reg;

    logic        accept;
    logic        out_free;
    logic [5:0]  wcur;
    logic [14:0] pitch_sum;
    logic [12:0] pitch;
    logic [12:0] col;
    logic [1:0]  lvl;
    logic [23:0] pix_color;
    logic        draw_bad;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign wcur      = wrd_valid_q ? wrd_q : 6'd0;
    assign pitch_sum = 15'(total_reg) + 15'd3;
    assign pitch     = pitch_sum[14:2];
    assign col       = start_reg + 13'(i_reg);
    assign draw_bad  = (in_code >= 16'(MAX_CHARS)) || (in_row >= 8'(height_reg))
                       || (in_row >= 8'(MAX_HEIGHT));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_gw_reg, out_color_reg, out_py_reg, out_px_reg};
    assign m_tuser  = {out_status_reg, out_pv_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        case (srd_q >> (3'(2'd3 - sel_reg) * 3'd2) & 8'd3)
            8'd0:    lvl = 2'd0;
            8'd1:    lvl = 2'd1;
            8'd2:    lvl = 2'd2;
            default: lvl = 2'd3;
        endcase
        case (lvl)
            2'd0:    pix_color = back_reg;
            2'd1:    pix_color = blend(1'b0, text_reg, back_reg);
            2'd2:    pix_color = blend(1'b1, text_reg, back_reg);
            default: pix_color = text_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wrd_en     = 1'b0;
        wrd_addr   = in_code[CODE_W-1:0];
        srd_en     = 1'b0;
        srd_addr   = STRIP_W'(base_reg + 18'(col[12:2]));
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_LOAD_WIDTH:
                        begin
                            if (in_code < 16'(MAX_CHARS))
                            begin
                                wrd_en     = 1'b1;
                                state_next = ST_WLOAD;
                            end
                        end
                        OP_DRAW:
                        begin
                            if (draw_bad)
                                state_next = ST_RES;
                            else
                            begin
                                wrd_en     = 1'b1;
                                wrd_addr   = '0;
                                state_next = ST_SWEEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WLOAD:
                state_next = ST_IDLE;
            ST_SWEEP:
            begin
                if (cnt_reg == code_reg)
                    state_next = (wcur == 6'd0) ? ST_RES : ST_PIX_RD;
                else
                begin
                    wrd_en   = 1'b1;
                    wrd_addr = cnt_reg + 1'b1;
                end
            end
            ST_PIX_RD:
            begin
                srd_en     = 1'b1;
                state_next = ST_PIX_LD;
            end
            ST_PIX_LD:
            begin
                if (out_free)
                    state_next = (i_reg + 6'd1 == w_reg) ? ST_IDLE : ST_PIX_RD;
            end
            ST_RES:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wrd_en)
            wrd_q <= wmem[wrd_addr];
        if (state_reg == ST_WLOAD)
            wmem[code_reg] <= wload_reg;
    end

    always_ff @(posedge clk)
    begin
        if (srd_en)
            srd_q <= smem[srd_addr];
        if (accept && s_tuser == OP_LOAD_STRIP)
            smem[in_addr] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CHARS; k++)
                wvalid_reg[k] <= 1'b0;
            wrd_valid_q <= 1'b0;
        end
        else
        begin
            if (wrd_en)
                wrd_valid_q <= wvalid_reg[wrd_addr];
            if (state_reg == ST_WLOAD)
                wvalid_reg[code_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            text_reg      <= 24'h000000;
            back_reg      <= 24'hFFFFFF;
            height_reg    <= 6'd16;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEXT_COLOR:  text_reg   <= cfg_data;
                    REG_BACK_COLOR:  back_reg   <= cfg_data;
                    REG_FONT_HEIGHT: height_reg <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_WLOAD)
                total_reg <= total_reg - 14'(wcur) + 14'(wload_reg);
            if ((state_reg == ST_PIX_LD || state_reg == ST_RES) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= in_code[CODE_W-1:0];
            wload_reg <= (in_data > 8'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH) : in_data[5:0];
            x_reg     <= in_x;
            py_reg    <= 13'(in_y) + 13'(in_row);
            bad_reg   <= draw_bad;
            cnt_reg   <= '0;
            start_reg <= '0;
            i_reg     <= '0;
            w_reg     <= '0;
            base_reg  <= 18'(in_row[ROW_W-1:0]) * 18'(pitch);
        end
        if (state_reg == ST_SWEEP)
        begin
            if (cnt_reg == code_reg)
                w_reg <= wcur;
            else
            begin
                start_reg <= start_reg + 13'(wcur);
                cnt_reg   <= cnt_reg + 1'b1;
            end
        end
        if (state_reg == ST_PIX_RD)
            sel_reg <= col[1:0];
        if (state_reg == ST_PIX_LD && out_free)
        begin
            out_px_reg     <= 13'(x_reg) + 13'(i_reg);
            out_py_reg     <= py_reg;
            out_color_reg  <= pix_color;
            out_gw_reg     <= w_reg;
            out_pv_reg     <= 1'b1;
            out_status_reg <= 1'b0;
            out_last_reg   <= (i_reg + 6'd1 == w_reg);
            i_reg          <= i_reg + 6'd1;
        end
        if (state_reg == ST_RES && out_free)
        begin
            out_px_reg     <= 13'(x_reg);
            out_py_reg     <= py_reg;
            out_color_reg  <= '0;
            out_gw_reg     <= '0;
            out_pv_reg     <= 1'b0;
            out_status_reg <= bad_reg;
            out_last_reg   <= 1'b1;
        end
    end

endmodule
